// ===== sv/pra_pkg.sv =====
// Package with shared constants, codes and controller/datapath types for the page run allocator.
package pra_pkg;

  localparam int PAGES_DEFAULT      = 128;
  localparam int PAGE_BYTES_DEFAULT = 4096;

  localparam int AddrW   = 32;
  localparam int SizeW   = 20;
  localparam int CountW  = 8;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_BASE   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PCOUNT = 1'b1;

  localparam logic [CountW-1:0] PCOUNT_RESET = 8'd128;

  localparam logic [1:0] CODE_FREE = 2'd0;
  localparam logic [1:0] CODE_END  = 2'd1;
  localparam logic [1:0] CODE_CONT = 2'd2;

  localparam logic [StatusW-1:0] ST_ALLOC = 2'd0;
  localparam logic [StatusW-1:0] ST_OOM   = 2'd1;
  localparam logic [StatusW-1:0] ST_FREED = 2'd2;
  localparam logic [StatusW-1:0] ST_BAD   = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic               cap;
    logic               cand_step;
    logic               ptr_cand;
    logic               ptr_idx;
    logic               ptr_inc;
    logic               mem_we;
    logic               we_mark;
    logic               res_set;
    logic [StatusW-1:0] res_status;
    logic               out_load;
  } pra_cmd_t;

  typedef struct packed {
    logic fit;
    logic rd_free;
    logic rd_cont;
    logic ptr_last;
    logic ptr_max;
    logic free_bad;
    logic req_free;
  } pra_sts_t;

endpackage

// ===== sv/pra_ifs.sv =====
// Valid/ready channel interfaces for request and response beats.
interface pra_req_if import pra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [SizeW-1:0] req_size;
  logic [AddrW-1:0] free_address;

  modport source (output valid, output req_type, output req_size, output free_address,
                  input ready);
  modport sink (input valid, input req_type, input req_size, input free_address,
                output ready);
endinterface

interface pra_rsp_if import pra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [AddrW-1:0]   run_address;
  logic [StatusW-1:0] status;

  modport source (output valid, output run_address, output status, input ready);
  modport sink (input valid, input run_address, input status, output ready);
endinterface

// ===== sv/pra_datapath.sv =====
// Datapath: configuration registers, page map memory, scan pointers and result registers.
module pra_datapath import pra_pkg::*; #(
  parameter int PAGES      = PAGES_DEFAULT,
  parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pra_cmd_t            cmd_i,
  output pra_sts_t            sts_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [AddrW-1:0]    cfg_wdata_i,
  input  logic                req_type_i,
  input  logic [SizeW-1:0]    req_size_i,
  input  logic [AddrW-1:0]    free_address_i,
  output logic [AddrW-1:0]    run_address_o,
  output logic [StatusW-1:0]  status_o
);

  localparam int PageShift = $clog2(PAGE_BYTES);
  localparam int IdxW      = $clog2(PAGES);
  localparam int CntW      = $clog2(PAGES + 1);
  localparam int SegW      = SizeW + 1 - PageShift;
  localparam int SumW      = ((SegW > CntW) ? SegW : CntW) + 1;
  localparam int OffW      = AddrW - PageShift;

  logic [AddrW-1:0]   base_q;
  logic [CountW-1:0]  pcount_q;
  logic [IdxW-1:0]    ptr_q, ptr_d;
  logic               req_free_q;
  logic [SegW-1:0]    seg_q;
  logic [AddrW-1:0]   faddr_q;
  logic [CntW-1:0]    cand_q;
  logic [1:0]         rd_q;
  logic [AddrW-1:0]   res_addr_q;
  logic [StatusW-1:0] res_status_q;
  logic [AddrW-1:0]   out_addr_q;
  logic [StatusW-1:0] out_status_q;
  logic [1:0]         map_q [PAGES];

  logic [15:0]        pc_w;
  logic [CntW-1:0]    act;
  logic [SegW-1:0]    seg_raw, seg_in;
  logic [SumW-1:0]    run_end;
  logic [AddrW:0]     diff;
  logic [OffW-1:0]    page_off;
  logic               ptr_last;
  logic [1:0]         wcode;

  assign pc_w    = 16'(pcount_q);
  assign act     = (pc_w > 16'(PAGES)) ? CntW'(PAGES) : CntW'(pcount_q);
  assign seg_raw = SegW'(req_size_i[SizeW-1:PageShift]) + SegW'(|req_size_i[PageShift-1:0]);
  assign seg_in  = (seg_raw == '0) ? SegW'(1) : seg_raw;
  assign run_end = SumW'(cand_q) + SumW'(seg_q);
  assign diff    = {1'b0, faddr_q} - {1'b0, base_q};
  assign page_off = diff[AddrW-1:PageShift];
  assign ptr_last = (SumW'(ptr_q) + SumW'(1)) == run_end;
  assign wcode   = cmd_i.we_mark ? (ptr_last ? CODE_END : CODE_CONT) : CODE_FREE;

  assign sts_o.fit      = run_end <= SumW'(act);
  assign sts_o.rd_free  = rd_q == CODE_FREE;
  assign sts_o.rd_cont  = rd_q == CODE_CONT;
  assign sts_o.ptr_last = ptr_last;
  assign sts_o.ptr_max  = ptr_q == IdxW'(PAGES - 1);
  assign sts_o.free_bad = diff[AddrW] || (page_off >= OffW'(act));
  assign sts_o.req_free = req_free_q;

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_cand) begin
      ptr_d = cand_q[IdxW-1:0];
    end else if (cmd_i.ptr_idx) begin
      ptr_d = page_off[IdxW-1:0];
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      pcount_q <= PCOUNT_RESET;
      ptr_q    <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE:   base_q   <= cfg_wdata_i;
          CFG_PCOUNT: pcount_q <= cfg_wdata_i[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_free_q <= req_type_i;
      seg_q      <= seg_in;
      faddr_q    <= free_address_i;
      cand_q     <= '0;
    end else if (cmd_i.cand_step) begin
      cand_q <= CntW'(run_end);
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_addr_q   <= (cmd_i.res_status == ST_ALLOC) ?
                      base_q + (AddrW'(cand_q) << PageShift) : '0;
    end
    if (cmd_i.out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      map_q[ptr_q] <= wcode;
    end
    rd_q <= map_q[ptr_q];
  end

  assign run_address_o = out_addr_q;
  assign status_o      = out_status_q;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < PAGES)
    else $error("page pointer beyond map depth");
  a_mark_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mem_we && cmd_i.we_mark) |-> (SumW'(ptr_q) < run_end && sts_o.fit))
    else $error("run mark outside the candidate run");
`endif

endmodule

// ===== sv/pra_ctrl.sv =====
// Controller state machine that sequences clearing, allocation scans, frees and response beats.
module pra_ctrl import pra_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  pra_sts_t sts_i,
  output pra_cmd_t cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_CAND  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_MARK  = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FWR   = 4'd9;
  localparam logic [3:0] S_RESP  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o.mem_we = 1'b1;
        if (sts_i.ptr_max) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        state_d = (sts_i.req_free == REQ_FREE) ? S_FCHK : S_CAND;
      end
      S_CAND: begin
        if (sts_i.fit) begin
          cmd_o.ptr_cand = 1'b1;
          state_d        = S_RD;
        end else begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_OOM;
          state_d          = S_RESP;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (!sts_i.rd_free) begin
          cmd_o.cand_step = 1'b1;
          state_d         = S_CAND;
        end else if (sts_i.ptr_last) begin
          cmd_o.ptr_cand = 1'b1;
          state_d        = S_MARK;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_MARK: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.we_mark = 1'b1;
        if (sts_i.ptr_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_ALLOC;
          state_d          = S_RESP;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_FCHK: begin
        if (sts_i.free_bad) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_BAD;
          state_d          = S_RESP;
        end else begin
          cmd_o.ptr_idx = 1'b1;
          state_d       = S_FRD;
        end
      end
      S_FRD: begin
        state_d = S_FWR;
      end
      S_FWR: begin
        cmd_o.mem_we = 1'b1;
        if (sts_i.rd_cont && !sts_i.ptr_max) begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_FRD;
        end else begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_FREED;
          state_d          = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_mark_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK) |-> sts_i.fit)
    else $error("marking a run that does not fit the active pages");
  a_beat_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESP))
    else $error("response beat raised outside the response state");
  a_free_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FWR) |-> ($past(state_q) == S_FRD))
    else $error("map cleared without a preceding read");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_set |=> (state_q == S_RESP))
    else $error("result set without moving to the response state");
`endif

endmodule

// ===== sv/page_run_allocator.sv =====
// Top level of the page run allocator: request and response channels, configuration port.
// After reset the block clears its page map one page a cycle and takes no request until
// that pass is done; configuration writes are taken throughout. An allocate request tries
// start pages in turn, examines the map entries of each candidate run and marks the pages
// of the run that it finds; a free clears the map entries of its run, and a rejected free
// writes no entry. The single page map memory is addressed by one pointer and gives one
// registered read each cycle, with a write to the same entry when enabled.
// One request is in work at a time; a new request is taken while the previous response beat
// still waits at the output. PAGE_BYTES must be a power of two.
module page_run_allocator import pra_pkg::*; #(
  parameter int PAGES      = PAGES_DEFAULT,
  parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pra_req_if.sink            req_i,
  pra_rsp_if.source          rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [AddrW-1:0]   cfg_wdata_i
);

  pra_cmd_t cmd;
  pra_sts_t sts;

  pra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pra_datapath #(
    .PAGES      (PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_i.req_type),
    .req_size_i     (req_i.req_size),
    .free_address_i (req_i.free_address),
    .run_address_o  (rsp_o.run_address),
    .status_o       (rsp_o.status)
  );

endmodule
